// ----- hdl/lrupl_pkg.sv -----
`timescale 1ns / 1ps
// shared types and codes for the lru page recency list
// no dependencies

package lrupl_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int PAGE_BITS_DEF = 31;

  typedef enum logic [2:0] {
    ACT_SEARCH = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_TOUCH  = 3'd2,
    ACT_EVICT  = 3'd3,
    ACT_REMOVE = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOTFOUND = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SH_HOLD  = 2'd0,
    SH_LEFT  = 2'd1,
    SH_RIGHT = 2'd2
  } shift_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CMP  = 2'd1,
    ST_UPD  = 2'd2
  } state_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic   live;
    logic   last;
    shift_t shift;
  } cell_ctl_t;

endpackage

// ----- hdl/lrupl_cell.sv -----
`timescale 1ns / 1ps
// one entry of the recency chain: holds a page, compares it, shifts to a neighbor
// depends on lrupl_pkg

module lrupl_cell #(
  parameter int PAGE_BITS = lrupl_pkg::PAGE_BITS_DEF
) (
  input  logic                  clk,
  input  lrupl_pkg::cell_ctl_t  ctl,
  input  logic [PAGE_BITS-1:0]  page,
  input  logic [PAGE_BITS-1:0]  left_in,
  input  logic [PAGE_BITS-1:0]  right_in,
  output logic [PAGE_BITS-1:0]  entry,
  output logic                  match,
  output logic [PAGE_BITS-1:0]  tap
);
  import lrupl_pkg::*;

  logic [PAGE_BITS-1:0] entry_next;

  always_comb begin
    case (ctl.shift)
      SH_LEFT:  entry_next = left_in;
      SH_RIGHT: entry_next = right_in;
      default:  entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  assign match = ctl.live && (entry == page);
  // only the lru cell drives the evict bus
  assign tap   = ctl.last ? entry : '0;

endmodule

// ----- hdl/lru_page_recency_list_top.sv -----
`timescale 1ns / 1ps
// lru page recency list: chain of DEPTH cells ordered mru first, plus sequencer
// an accepted word is registered, compared in ST_CMP, then in ST_UPD the chain shifts and the result is registered
// ST_UPD waits while out_stall holds the previous result; a new word is taken only back in idle
// rst clears the fill count and the handshake state; entries are not cleared
// depends on lrupl_pkg and lrupl_cell

module lru_page_recency_list_top #(
  parameter int   DEPTH     = lrupl_pkg::DEPTH_DEF,
  parameter int   PAGE_BITS = lrupl_pkg::PAGE_BITS_DEF,
  localparam int  RANK_W    = $clog2(DEPTH),
  localparam int  LEN_W     = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           action,
  input  logic [PAGE_BITS-1:0] page,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 hit,
  output logic [RANK_W-1:0]    rank,
  output logic [PAGE_BITS-1:0] page_out,
  output logic [LEN_W-1:0]     length,
  output logic                 empty_res,
  output logic [1:0]           status
);
  import lrupl_pkg::*;

  state_t               state, state_next;
  logic [2:0]           req_action;
  logic [PAGE_BITS-1:0] req_page;
  logic [LEN_W-1:0]     fill, fill_next;
  logic [DEPTH-1:0]     first;
  logic [PAGE_BITS-1:0] ev_page;

  logic [PAGE_BITS-1:0] ent  [DEPTH];
  logic [PAGE_BITS-1:0] tap  [DEPTH];
  cell_ctl_t            ctl  [DEPTH];
  shift_t               shift_v [DEPTH];
  logic [DEPTH-1:0]     mvec, first_c, below, le_m, ge_m;
  logic [PAGE_BITS-1:0] ev_or;
  logic [RANK_W-1:0]    rank_c;
  logic                 hit_any, full, go;

  logic                 hit_r;
  logic [RANK_W-1:0]    rank_r;
  logic [PAGE_BITS-1:0] pout_r;
  status_t              stat_r;

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [PAGE_BITS-1:0] lin, rin;
    if (i == 0) begin : g_head
      assign lin = req_page;
    end else begin : g_mid
      assign lin = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign rin = ent[i];
    end else begin : g_body
      assign rin = ent[i+1];
    end
    assign ctl[i].live  = fill > LEN_W'(i);
    assign ctl[i].last  = fill == LEN_W'(i + 1);
    assign ctl[i].shift = go ? shift_v[i] : SH_HOLD;

    lrupl_cell #(.PAGE_BITS(PAGE_BITS)) u_cell (
      .clk      (clk),
      .ctl      (ctl[i]),
      .page     (req_page),
      .left_in  (lin),
      .right_in (rin),
      .entry    (ent[i]),
      .match    (mvec[i]),
      .tap      (tap[i])
    );
  end

  // newest match isolated as one-hot, evict page gathered from the lru cell
  always_comb begin
    first_c = mvec & (~mvec + DEPTH'(1));
    ev_or   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      ev_or = ev_or | tap[i];
    end
  end

  always_comb begin
    below   = first - DEPTH'(1);
    le_m    = first | below;
    ge_m    = ~below;
    hit_any = |first;
    full    = fill == LEN_W'(DEPTH);
    rank_c  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) rank_c = rank_c | RANK_W'(i);
    end
  end

  // shift plan and result for the update cycle
  always_comb begin
    fill_next = fill;
    hit_r     = 1'b0;
    rank_r    = '0;
    pout_r    = req_page;
    stat_r    = STAT_OK;
    for (int i = 0; i < DEPTH; i++) shift_v[i] = SH_HOLD;
    case (req_action)
      ACT_SEARCH: begin
        hit_r  = hit_any;
        rank_r = rank_c;
        stat_r = hit_any ? STAT_OK : STAT_NOTFOUND;
      end
      ACT_ADD: begin
        if (full) begin
          stat_r = STAT_FULL;
        end else begin
          fill_next = fill + LEN_W'(1);
          for (int i = 0; i < DEPTH; i++) shift_v[i] = SH_LEFT;
        end
      end
      ACT_TOUCH: begin
        hit_r  = hit_any;
        rank_r = rank_c;
        stat_r = hit_any ? STAT_OK : STAT_NOTFOUND;
        if (hit_any) begin
          for (int i = 0; i < DEPTH; i++) shift_v[i] = le_m[i] ? SH_LEFT : SH_HOLD;
        end
      end
      ACT_EVICT: begin
        if (fill == '0) begin
          stat_r = STAT_EMPTY;
          pout_r = '0;
        end else begin
          pout_r    = ev_page;
          fill_next = fill - LEN_W'(1);
        end
      end
      ACT_REMOVE: begin
        hit_r  = hit_any;
        rank_r = rank_c;
        stat_r = hit_any ? STAT_OK : STAT_NOTFOUND;
        if (hit_any) begin
          fill_next = fill - LEN_W'(1);
          for (int i = 0; i < DEPTH; i++) shift_v[i] = ge_m[i] ? SH_RIGHT : SH_HOLD;
        end
      end
      default: begin
        stat_r = STAT_OK;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    go         = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        // wait here while the previous result is still held
        go = !out_valid || !out_stall;
        if (go) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      req_action <= action;
      req_page   <= page;
    end
    if (state == ST_CMP) begin
      first   <= first_c;
      ev_page <= ev_or;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (go) fill <= fill_next;
      out_valid <= go || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      hit       <= hit_r;
      rank      <= rank_r;
      page_out  <= pout_r;
      length    <= fill_next;
      empty_res <= (fill_next == '0);
      status    <= stat_r;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= LEN_W'(DEPTH))
    else $error("fill count beyond depth");

  a_first_onehot: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPD |-> $onehot0(first))
    else $error("more than one newest match selected");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_FULL |-> length == LEN_W'(DEPTH))
    else $error("full status with room left");

  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_EMPTY |-> page_out == '0 && length == '0)
    else $error("empty status with entries held");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == ST_CMP)
    else $error("accepted word did not enter compare");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// testbench for lru_page_recency_list_top: directed and random requests checked
// against a behavioral recency list kept in the bench; depends on lrupl_pkg

module tb_top;
  import lrupl_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int STALL_MAX  = 2000;
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [30:0] PAGE_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic        hit;
    logic [5:0]  rank;
    logic [30:0] page_out;
    logic [6:0]  length;
    logic        empty_res;
    status_t     status;
  } recency_res_t;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} traffic_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  action = '0;
  logic [30:0] page = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        hit;
  logic [5:0]  rank;
  logic [30:0] page_out;
  logic [6:0]  length;
  logic        empty_res;
  logic [1:0]  status;

  // bench copy of the recency list, mru at index 0
  logic [30:0]  lru_pages [DEPTH];
  int           lru_fill = 0;
  int           peak_fill = 0;
  recency_res_t expected_results [$];

  int mismatches = 0;
  int words_sent = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int full_seen = 0;
  int empty_seen = 0;
  int idle_cycles = 0;
  int rx_hold = 0;

  lru_page_recency_list_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .page      (page),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .rank      (rank),
    .page_out  (page_out),
    .length    (length),
    .empty_res (empty_res),
    .status    (status)
  );

  always #10 clk = ~clk;

  function automatic void push_front(logic [30:0] pg);
    for (int i = lru_fill; i > 0; i--) lru_pages[i] = lru_pages[i-1];
    lru_pages[0] = pg;
    lru_fill++;
    if (lru_fill > peak_fill) peak_fill = lru_fill;
  endfunction

  function automatic recency_res_t predict_request(logic [2:0] act, logic [30:0] pg);
    recency_res_t r;
    int pos;
    r.hit      = 1'b0;
    r.rank     = '0;
    r.page_out = pg;
    r.status   = STAT_OK;
    pos = -1;
    case (act)
      ACT_SEARCH, ACT_TOUCH, ACT_REMOVE: begin
        for (int i = lru_fill - 1; i >= 0; i--)
          if (lru_pages[i] == pg) pos = i;
        if (pos < 0) begin
          r.status = STAT_NOTFOUND;
        end else begin
          r.hit  = 1'b1;
          r.rank = 6'(pos);
          if (act != ACT_SEARCH) begin
            for (int i = pos; i + 1 < lru_fill; i++) lru_pages[i] = lru_pages[i+1];
            lru_fill--;
          end
          if (act == ACT_TOUCH) push_front(pg);
        end
      end
      ACT_ADD: begin
        if (lru_fill >= DEPTH) r.status = STAT_FULL;
        else push_front(pg);
      end
      ACT_EVICT: begin
        if (lru_fill == 0) begin
          r.status   = STAT_EMPTY;
          r.page_out = '0;
        end else begin
          r.page_out = lru_pages[lru_fill-1];
          lru_fill--;
        end
      end
      default: ;
    endcase
    r.length    = 7'(lru_fill);
    r.empty_res = (lru_fill == 0);
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(input logic [2:0] act, input logic [30:0] pg);
    @(negedge clk);
    in_valid = 1'b1;
    action   = act;
    page     = pg;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_request(act, pg));
    words_sent++;
  endtask

  task automatic idle_input(input int n);
    @(negedge clk);
    in_valid = 1'b0;
    action   = 3'($urandom);
    page     = 31'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    int r;
    if (rx_hold == 0) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        out_stall = 1'b0;
        rx_hold   = $urandom_range(1, 20);
      end else if (r < 80) begin
        out_stall = 1'b1;
        rx_hold   = $urandom_range(1, 3);
      end else if (r < 95) begin
        out_stall = 1'b0;
        rx_hold   = 1;
      end else begin
        out_stall = 1'b1;
        rx_hold   = $urandom_range(10, 40);
      end
    end
    rx_hold--;
  end

  always @(posedge clk) begin
    recency_res_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (hit) hits_seen++;
      if (status == STAT_FULL) full_seen++;
      if (status == STAT_EMPTY) empty_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word, page_out %0h status %0d",
                 $time, page_out, status);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        report_field("hit", want.hit, hit);
        report_field("rank", want.rank, rank);
        report_field("page_out", want.page_out, page_out);
        report_field("length", want.length, length);
        report_field("empty_res", want.empty_res, empty_res);
        report_field("status", want.status, status);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_MAX) begin
      $display("%0t: timeout, no word moved for %0d cycles", $time, STALL_MAX);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_empty_list();
    send_word(ACT_SEARCH, 31'h0);
    send_word(ACT_TOUCH, PAGE_MAX);
    send_word(ACT_REMOVE, 31'h1234);
    send_word(ACT_EVICT, PAGE_MAX);
    send_word(ACT_UNUSED_LO, 31'h0);
    send_word(ACT_UNUSED_LO + 3'd1, PAGE_MAX);
    send_word(ACT_UNUSED_LO + 3'd2, 31'h5555_5555);
  endtask

  task automatic test_basic_ops();
    send_word(ACT_ADD, 31'h0);
    send_word(ACT_ADD, PAGE_MAX);
    send_word(ACT_ADD, 31'h0);
    send_word(ACT_SEARCH, 31'h0);
    idle_input(2);
    send_word(ACT_SEARCH, PAGE_MAX);
    send_word(ACT_SEARCH, 31'h2AAA_AAAA);
    send_word(ACT_TOUCH, PAGE_MAX);
    send_word(ACT_SEARCH, 31'h0);
    send_word(ACT_REMOVE, 31'h0);
    send_word(ACT_ADD, 31'h5555_5555);
    send_word(ACT_ADD, 31'h2AAA_AAAA);
    send_word(ACT_UNUSED_LO + 3'd2, 31'h0);
    send_word(ACT_TOUCH, 31'h1);
    send_word(ACT_REMOVE, 31'h7);
    send_word(ACT_EVICT, 31'h0);
    send_word(ACT_EVICT, 31'h0);
    send_word(ACT_EVICT, 31'h0);
    send_word(ACT_EVICT, 31'h0);
    send_word(ACT_EVICT, 31'h0);
    wait_drained();
  endtask

  task automatic test_full_list();
    logic [30:0] oldest;
    for (int i = 0; i < DEPTH; i++) begin
      // one fixed page, 3, placed among the random pages of the full list
      send_word(ACT_ADD, (i == 40) ? 31'h3 : 31'($urandom));
      if ($urandom_range(0, 3) == 0) idle_input(gap_len() + 1);
    end
    send_word(ACT_ADD, PAGE_MAX);
    oldest = lru_pages[DEPTH-1];
    send_word(ACT_SEARCH, oldest);
    send_word(ACT_TOUCH, oldest);
    send_word(ACT_SEARCH, lru_pages[DEPTH-1]);
    send_word(ACT_REMOVE, lru_pages[DEPTH-1]);
    send_word(ACT_ADD, 31'h0);
    send_word(ACT_ADD, 31'h1);
    while (lru_fill > 0) begin
      if ($urandom_range(0, 4) == 0) send_word(ACT_SEARCH, lru_pages[lru_fill-1]);
      send_word(ACT_EVICT, 31'($urandom));
      if ($urandom_range(0, 3) == 0) idle_input(gap_len() + 1);
    end
    send_word(ACT_EVICT, 31'h0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_items);
    logic [30:0]    pool [16];
    traffic_phase_t phase;
    bit             no_gaps;
    int             r, g;
    int             lim [6];
    logic [2:0]     act;
    logic [30:0]    pg;
    phase   = PH_GROW;
    no_gaps = 1'b0;
    foreach (pool[i]) pool[i] = 31'($urandom);
    for (int k = 0; k < n_items; k++) begin
      if (k % 200 == 0) begin
        phase   = traffic_phase_t'($urandom_range(0, 2));
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      if (k == n_items / 2) wait_drained();
      // cumulative weights: search, add, touch, evict, remove, unused
      case (phase)
        PH_GROW:   lim = '{20, 65, 80, 85, 95, 100};
        PH_SHRINK: lim = '{20, 30, 45, 75, 95, 100};
        default:   lim = '{25, 50, 70, 80, 95, 100};
      endcase
      r = $urandom_range(0, 99);
      if (r < lim[0])      act = ACT_SEARCH;
      else if (r < lim[1]) act = ACT_ADD;
      else if (r < lim[2]) act = ACT_TOUCH;
      else if (r < lim[3]) act = ACT_EVICT;
      else if (r < lim[4]) act = ACT_REMOVE;
      else                 act = ACT_UNUSED_LO + 3'($urandom_range(0, 2));
      r = $urandom_range(0, 99);
      if (act == ACT_SEARCH || act == ACT_TOUCH || act == ACT_REMOVE) begin
        if (r < 50 && lru_fill > 0) pg = lru_pages[$urandom_range(0, lru_fill - 1)];
        else if (r < 80)            pg = pool[$urandom_range(0, 15)];
        else                        pg = 31'($urandom);
      end else if (act == ACT_ADD && r < 60) begin
        pg = pool[$urandom_range(0, 15)];
      end else begin
        pg = 31'($urandom);
      end
      send_word(act, pg);
      g = no_gaps ? 0 : gap_len();
      if (g > 0) idle_input(g);
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_list();
    test_basic_ops();
    test_full_list();
    test_random_traffic(1800);
    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered: %0d words sent, %0d results, %0d hits, peak fill %0d of %0d",
             words_sent, results_seen, hits_seen, peak_fill, DEPTH);
    $display("covered: %0d full-list rejects, %0d evicts from an empty list",
             full_seen, empty_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- lru_page_recency_list_top.f -----
hdl/lrupl_pkg.sv
hdl/lrupl_cell.sv
hdl/lru_page_recency_list_top.sv
tb/tb_top.sv
